@@ rtl/jpeg_frame_header_scanner_defines.svh @@
// Assertion macros shared by the frame header scanner checkers.
`ifndef JPEG_FRAME_HEADER_SCANNER_DEFINES_SVH
`define JPEG_FRAME_HEADER_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define JFHS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define JFHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/jfhs_pkg.sv @@
// Types and constants of the JPEG frame header scanner.
package jfhs_pkg;

	localparam int LenWidth   = 32;
	localparam int DataWidth  = 8;
	localparam int DimWidth   = 16;
	localparam int CompWidth  = 8;
	localparam int AddrWidth  = 3;
	localparam int DeltaWidth = 17;

	// Register index (paddr[2]) of stream_length
	localparam logic REG_STREAM_LENGTH = 1'b0;

	// Marker bytes
	localparam logic [DataWidth-1:0] MARK_PREFIX = 8'hFF;
	localparam logic [DataWidth-1:0] MARK_SOI    = 8'hD8;
	localparam logic [DataWidth-1:0] MARK_SOF0   = 8'hC0;
	localparam logic [DataWidth-1:0] MARK_SOF2   = 8'hC2;
	localparam logic [DataWidth-1:0] MARK_STUFF  = 8'h00;

	localparam int EndMargin    = 10;
	localparam int MinStreamLen = 4;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_BAD_FORMAT = 2'd1,
		ST_NO_FRAME   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SOI2,
		PH_SEEK,
		PH_MARKER,
		PH_LENHI,
		PH_LENLO,
		PH_FRAME
	} phase_t;

	typedef struct packed {
		status_t              status;
		logic [DimWidth-1:0]  image_height;
		logic [DimWidth-1:0]  image_width;
		logic [CompWidth-1:0] component_count;
		logic                 is_grayscale;
	} result_t;

endpackage

@@ rtl/jfhs_cfg.sv @@
// APB register block holding the stream length.
module jfhs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [jfhs_pkg::AddrWidth-1:0]   paddr,
	input  logic [jfhs_pkg::LenWidth-1:0]    pwdata,
	output logic [jfhs_pkg::LenWidth-1:0]    prdata,
	output logic                             pready,
	output logic [jfhs_pkg::LenWidth-1:0]    stream_length
);
	import jfhs_pkg::*;

	logic [LenWidth-1:0] stream_length_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_STREAM_LENGTH);

	// Register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= '0;
		end else if (wr_en) begin
			stream_length_q <= pwdata;
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[2])
			REG_STREAM_LENGTH: prdata = stream_length_q;
			default:           prdata = '0;
		endcase
	end

	assign stream_length = stream_length_q;

endmodule

@@ rtl/jfhs_core.sv @@
// Input register, scan state and per-byte next-state logic.
module jfhs_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [jfhs_pkg::LenWidth-1:0]   stream_length,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [jfhs_pkg::DataWidth-1:0]  data_byte,
	input  logic                            start_of_stream,
	input  logic                            res_free,
	output logic                            res_load,
	output jfhs_pkg::result_t               res_d
);
	import jfhs_pkg::*;

	localparam logic [LenWidth-1:0] OffHeightHi = LenWidth'(5);
	localparam logic [LenWidth-1:0] OffHeightLo = LenWidth'(6);
	localparam logic [LenWidth-1:0] OffWidthHi  = LenWidth'(7);
	localparam logic [LenWidth-1:0] OffWidthLo  = LenWidth'(8);
	localparam logic [LenWidth-1:0] OffComps    = LenWidth'(9);
	localparam logic [LenWidth-1:0] ScanStart   = LenWidth'(2);

	// Input stage
	logic                 valid_s1;
	logic [DataWidth-1:0] data_s1;
	logic                 start_s1;

	// Scan state
	logic [LenWidth-1:0]  byte_offset_q, byte_offset_d;
	logic [LenWidth-1:0]  scan_position_q, scan_position_d;
	phase_t               phase_q, phase_d;
	logic [DataWidth-1:0] length_high_q, length_high_d;
	logic [DimWidth-1:0]  height_acc_q, height_acc_d;
	logic [DimWidth-1:0]  width_acc_q, width_acc_d;

	logic                  adv;
	logic                  emit;
	logic                  short_stream;
	logic                  seek_hit;
	logic                  is_sof;
	logic [LenWidth-1:0]   frame_k;
	logic [DimWidth-1:0]   seg_len;
	logic                  do_move;
	logic [DeltaWidth-1:0] delta;
	logic [LenWidth:0]     np;
	logic [LenWidth+1:0]   np_margin;
	logic                  end_hit;
	logic                  move_ok;
	logic                  move_end;

	assign short_stream = stream_length < LenWidth'(MinStreamLen);
	assign seek_hit     = byte_offset_q == scan_position_q;
	assign frame_k      = byte_offset_q - scan_position_q;
	assign seg_len      = {length_high_q, data_s1};
	assign is_sof       = (data_s1 == MARK_SOF0) || (data_s1 == MARK_SOF2);

	// Scan move: which bytes advance the scan position, and by how much
	always_comb begin
		do_move = 1'b0;
		delta   = '0;
		case (phase_q)
			PH_SOI2: begin
				// scan position already holds 2 here
				do_move = (data_s1 == MARK_SOI);
			end
			PH_SEEK: begin
				do_move = seek_hit && (data_s1 != MARK_PREFIX);
				delta   = DeltaWidth'(1);
			end
			PH_MARKER: begin
				if (data_s1 == MARK_PREFIX) begin
					do_move = 1'b1;
					delta   = DeltaWidth'(1);
				end else if (data_s1 == MARK_STUFF) begin
					do_move = 1'b1;
					delta   = DeltaWidth'(2);
				end
			end
			PH_LENLO: begin
				do_move = 1'b1;
				if (seg_len < DimWidth'(2)) begin
					delta = DeltaWidth'(4);
				end else begin
					delta = {1'b0, seg_len} + DeltaWidth'(2);
				end
			end
			default: ;
		endcase
	end

	// New position and end-of-stream check, both without wrap
	assign np        = {1'b0, scan_position_q} + (LenWidth+1)'(delta);
	assign np_margin = {2'b00, scan_position_q}
		+ (LenWidth+2)'(delta + DeltaWidth'(EndMargin));
	assign end_hit   = np_margin >= {2'b00, stream_length};
	assign move_ok   = !start_s1 && do_move && !end_hit;
	assign move_end  = !start_s1 && do_move && end_hit;

	// Next phase
	always_comb begin
		if (start_s1) begin
			phase_d = (short_stream || data_s1 != MARK_PREFIX) ? PH_IDLE : PH_SOI2;
		end else begin
			unique case (phase_q)
				PH_IDLE: phase_d = PH_IDLE;
				PH_SOI2: phase_d = move_ok ? PH_SEEK : PH_IDLE;
				PH_SEEK: begin
					if (move_end) begin
						phase_d = PH_IDLE;
					end else if (seek_hit && data_s1 == MARK_PREFIX) begin
						phase_d = PH_MARKER;
					end else begin
						phase_d = PH_SEEK;
					end
				end
				PH_MARKER: begin
					if (is_sof) begin
						phase_d = PH_FRAME;
					end else if (data_s1 == MARK_PREFIX) begin
						phase_d = move_end ? PH_IDLE : PH_MARKER;
					end else if (data_s1 == MARK_STUFF) begin
						phase_d = move_end ? PH_IDLE : PH_SEEK;
					end else begin
						phase_d = PH_LENHI;
					end
				end
				PH_LENHI: phase_d = PH_LENLO;
				PH_LENLO: phase_d = move_end ? PH_IDLE : PH_SEEK;
				PH_FRAME: phase_d = (frame_k == OffComps) ? PH_IDLE : PH_FRAME;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// Datapath updates and result
	always_comb begin
		byte_offset_d         = byte_offset_q;
		scan_position_d       = scan_position_q;
		length_high_d         = length_high_q;
		height_acc_d          = height_acc_q;
		width_acc_d           = width_acc_q;
		emit                  = 1'b0;
		res_d.status          = ST_FOUND;
		res_d.image_height    = '0;
		res_d.image_width     = '0;
		res_d.component_count = '0;
		res_d.is_grayscale    = 1'b0;
		if (start_s1) begin
			byte_offset_d   = LenWidth'(1);
			scan_position_d = ScanStart;
			length_high_d   = '0;
			height_acc_d    = '0;
			width_acc_d     = '0;
			if (short_stream || data_s1 != MARK_PREFIX) begin
				emit         = 1'b1;
				res_d.status = ST_BAD_FORMAT;
			end
		end else if (phase_q != PH_IDLE) begin
			byte_offset_d = byte_offset_q + LenWidth'(1);
			if (move_ok) begin
				scan_position_d = np[LenWidth-1:0];
			end
			if (move_end) begin
				emit         = 1'b1;
				res_d.status = ST_NO_FRAME;
			end
			case (phase_q)
				PH_SOI2: begin
					if (data_s1 != MARK_SOI) begin
						emit         = 1'b1;
						res_d.status = ST_BAD_FORMAT;
					end
				end
				PH_LENHI: length_high_d = data_s1;
				PH_FRAME: begin
					if (frame_k == OffHeightHi) begin
						height_acc_d = {data_s1, 8'h00};
					end else if (frame_k == OffHeightLo) begin
						height_acc_d = height_acc_q | {8'h00, data_s1};
					end else if (frame_k == OffWidthHi) begin
						width_acc_d = {data_s1, 8'h00};
					end else if (frame_k == OffWidthLo) begin
						width_acc_d = width_acc_q | {8'h00, data_s1};
					end else if (frame_k == OffComps) begin
						emit                  = 1'b1;
						res_d.status          = ST_FOUND;
						res_d.image_height    = height_acc_q;
						res_d.image_width     = width_acc_q;
						res_d.component_count = data_s1;
						res_d.is_grayscale    = (data_s1 == CompWidth'(1));
					end
				end
				default: ;
			endcase
		end
	end

	// A byte without a result moves on even while the result register is full
	assign adv      = valid_s1 && (!emit || res_free);
	assign res_load = adv && emit;
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= start_of_stream;
		end
	end

	// Scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q   <= '0;
			scan_position_q <= ScanStart;
			phase_q         <= PH_IDLE;
			length_high_q   <= '0;
			height_acc_q    <= '0;
			width_acc_q     <= '0;
		end else if (adv) begin
			byte_offset_q   <= byte_offset_d;
			scan_position_q <= scan_position_d;
			phase_q         <= phase_d;
			length_high_q   <= length_high_d;
			height_acc_q    <= height_acc_d;
			width_acc_q     <= width_acc_d;
		end
	end

endmodule

@@ rtl/jfhs_result.sv @@
// Result register between the scan logic and the output channel.
module jfhs_result (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jfhs_pkg::result_t res_d,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output jfhs_pkg::result_t res_q
);
	import jfhs_pkg::*;

	logic out_valid_q;

	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Valid flag: set on load, cleared when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

@@ rtl/jpeg_frame_header_scanner.sv @@
// Scans a JPEG byte stream for the first baseline or progressive frame header
// and reports its height, width and component count. One byte is taken per
// cycle unless the input stalls; each byte passes an input register and the
// compare/update logic and then into the result register that drives the
// output. Bytes that produce no result keep flowing while a result waits
// on the output; a byte that produces a result stalls only while the single
// result register still holds an untaken result. Write stream_length over APB
// (address 0) before raising start_of_stream on the first byte of a stream.
module jpeg_frame_header_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jfhs_pkg::AddrWidth-1:0]  paddr,
	input  logic [jfhs_pkg::LenWidth-1:0]   pwdata,
	output logic [jfhs_pkg::LenWidth-1:0]   prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [jfhs_pkg::DataWidth-1:0]  data_byte,
	input  logic                            start_of_stream,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [jfhs_pkg::DimWidth-1:0]   image_height,
	output logic [jfhs_pkg::DimWidth-1:0]   image_width,
	output logic [jfhs_pkg::CompWidth-1:0]  component_count,
	output logic                            is_grayscale
);
	import jfhs_pkg::*;

	logic [LenWidth-1:0] stream_length;
	logic                res_free;
	logic                res_load;
	result_t             res_d;
	result_t             res_q;

	jfhs_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.stream_length (stream_length)
	);

	jfhs_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.stream_length   (stream_length),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.start_of_stream (start_of_stream),
		.res_free        (res_free),
		.res_load        (res_load),
		.res_d           (res_d)
	);

	jfhs_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res_d     (res_d),
		.free      (res_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign status          = res_q.status;
	assign image_height    = res_q.image_height;
	assign image_width     = res_q.image_width;
	assign component_count = res_q.component_count;
	assign is_grayscale    = res_q.is_grayscale;

endmodule

@@ rtl/jfhs_checker.sv @@
// Port-level checks for the frame header scanner, bound to the top level.
`include "jpeg_frame_header_scanner_defines.svh"

module jfhs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [1:0]                      status,
	input logic [jfhs_pkg::DimWidth-1:0]   image_height,
	input logic [jfhs_pkg::DimWidth-1:0]   image_width,
	input logic [jfhs_pkg::CompWidth-1:0]  component_count,
	input logic                            is_grayscale
);
	import jfhs_pkg::*;

	// Grayscale flag follows the component count of a found header
	`JFHS_ASSERT_IMPL(a_gray_flag, out_valid,
		is_grayscale == (status == ST_FOUND && component_count == CompWidth'(1)),
		"is_grayscale disagrees with status and component count")

	// Error results carry zero fields
	`JFHS_ASSERT_IMPL(a_err_zero, out_valid && status != ST_FOUND,
		image_height == '0 && image_width == '0 && component_count == '0,
		"error result with nonzero header fields")

	// Input never stalls while the result register is empty
	`JFHS_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready,
		"input stalled with no pending result")

	// A result not yet taken holds
	`JFHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(image_height)
			&& $stable(image_width) && $stable(component_count),
		"pending result changed before transfer")

endmodule

bind jpeg_frame_header_scanner jfhs_checker u_jfhs_checker (.*);
